// ===== rtl/aarm_pkg.sv =====
// Shared types, constants and datapath functions for the axis-angle rotation matrix unit.
package aarm_pkg;

  // Beat payloads
  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] turn_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic               axis_was_zero;
  } out_item_t;

  // Q30 constants
  localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Back pipeline depth: 32 root digits, then 31 quotient bits
  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 31;
  localparam int NumStages = SqrtSteps + DivSteps;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic signed [33:0] ang;
    logic               flip;
    logic               zero;
    logic [31:0]        l2;
    logic [2:0][15:0]   mag;
    logic [2:0]         neg;
  } work_t;

  // One slot of the shared CORDIC / root / divide pipeline
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
    logic               zero;
    logic [31:0]        l2;
    logic [2:0][15:0]   mag;
    logic [2:0]         neg;
    logic [31:0]        root;
    logic [33:0]        srem;
    logic [2:0][32:0]   drem;
    logic [2:0][30:0]   quo;
  } stage_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // One pipeline step: a CORDIC rotation while idx < steps, plus either a root digit or a quotient bit per lane
  function automatic stage_t stage_step(input stage_t s, input int idx, input int steps);
    stage_t             n;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] at;
    logic [1:0]         pair;
    logic [35:0]        rem2;
    logic [35:0]        trial;
    logic [32:0]        cur;
    logic [32:0]        sh;
    logic               qb;
    n = s;
    if (idx < steps) begin
      dx = s.y >>> idx;
      dy = s.x >>> idx;
      at = $signed({2'b00, atan_q30(5'(idx))});
      if (!s.z[33]) begin
        n.x = s.x - dx;
        n.y = s.y + dy;
        n.z = s.z - at;
      end else begin
        n.x = s.x + dx;
        n.y = s.y - dy;
        n.z = s.z + at;
      end
    end
    if (idx < SqrtSteps) begin
      pair = 2'b00;
      if (idx < SqrtSteps / 2) begin
        pair = 2'(s.l2 >> (30 - 2 * idx));
      end
      rem2  = {s.srem, pair};
      trial = {2'b00, s.root, 2'b01};
      if (rem2 >= trial) begin
        n.srem = 34'(rem2 - trial);
        n.root = {s.root[30:0], 1'b1};
      end else begin
        n.srem = rem2[33:0];
        n.root = {s.root[30:0], 1'b0};
      end
    end else if (idx < NumStages) begin
      for (int k = 0; k < 3; k++) begin
        cur = (idx == SqrtSteps) ? {2'b00, s.mag[k], 15'b0} : s.drem[k];
        sh  = {cur[31:0], 1'b0};
        qb  = (sh >= {1'b0, s.root});
        n.drem[k] = qb ? (sh - {1'b0, s.root}) : sh;
        n.quo[k]  = {s.quo[k][29:0], qb};
      end
    end
    return n;
  endfunction

  // Round to the entry format, clamp to +-1.0, keep 16 bits
  function automatic logic [15:0] to_out(input logic signed [35:0] v, input int efb);
    logic signed [39:0] w;
    logic signed [39:0] lim;
    int                 sh;
    sh  = 30 - efb;
    w   = 40'(v);
    lim = 40'sd1 <<< efb;
    if (sh > 0) begin
      w = (w + (40'sd1 <<< (sh - 1))) >>> sh;
    end
    if (w > lim) begin
      w = lim;
    end
    if (w < -lim) begin
      w = -lim;
    end
    return w[15:0];
  endfunction

endpackage

// ===== rtl/aarm_front.sv =====
// Front stage: accepts beats, reduces the angle, forms the squared axis length.
module aarm_front import aarm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     work_valid_o,
  input  logic     work_ready_i,
  output work_t    work_data_o
);

  logic               valid_q;
  work_t              data_q;
  work_t              data_d;
  logic signed [35:0] a0;
  logic signed [35:0] a1;
  logic signed [35:0] a2;
  logic signed [31:0] sq_x;
  logic signed [31:0] sq_y;
  logic signed [31:0] sq_z;
  logic [32:0]        l2_sum;

  assign in_ready_o   = !valid_q || work_ready_i;
  assign work_valid_o = valid_q;
  assign work_data_o  = data_q;

  // Reduce into (-pi, pi], then fold into [-pi/2, pi/2]
  always_comb begin
    a0 = {{2{in_data_i.turn_angle[15]}}, in_data_i.turn_angle, 18'b0};
    if (a0 > Q30_PI) begin
      a1 = a0 - Q30_TWO_PI;
    end else if (a0 <= -Q30_PI) begin
      a1 = a0 + Q30_TWO_PI;
    end else begin
      a1 = a0;
    end
    data_d.flip = 1'b1;
    if (a1 > Q30_HALF_PI) begin
      a2 = a1 - Q30_PI;
    end else if (a1 < -Q30_HALF_PI) begin
      a2 = a1 + Q30_PI;
    end else begin
      a2 = a1;
      data_d.flip = 1'b0;
    end
    data_d.ang = a2[33:0];
  end

  // Squared length and component magnitudes
  always_comb begin
    sq_x   = in_data_i.axis_x * in_data_i.axis_x;
    sq_y   = in_data_i.axis_y * in_data_i.axis_y;
    sq_z   = in_data_i.axis_z * in_data_i.axis_z;
    l2_sum = {1'b0, sq_x} + {1'b0, sq_y} + {1'b0, sq_z};
    data_d.l2   = l2_sum[31:0];
    data_d.zero = (l2_sum == '0);
    data_d.neg  = {in_data_i.axis_z[15], in_data_i.axis_y[15], in_data_i.axis_x[15]};
    data_d.mag[0] = in_data_i.axis_x[15] ? 16'(-in_data_i.axis_x) : in_data_i.axis_x;
    data_d.mag[1] = in_data_i.axis_y[15] ? 16'(-in_data_i.axis_y) : in_data_i.axis_y;
    data_d.mag[2] = in_data_i.axis_z[15] ? 16'(-in_data_i.axis_z) : in_data_i.axis_z;
  end

  // Hold the classified beat until the queue takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

// ===== rtl/aarm_fifo.sv =====
// Two-entry queue between the front and the back.
module aarm_fifo import aarm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  work_t push_data_i,
  output logic  pop_valid_o,
  input  logic  pop_ready_i,
  output work_t pop_data_o
);

  work_t       mem_q [2];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push;
  logic        pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/aarm_back.sv =====
// Back pipeline: CORDIC, square root, three dividers, products and output rounding.
module aarm_back import aarm_pkg::*; #(
  parameter int ENTRY_FRAC_BITS = 14,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      work_valid_i,
  output logic      work_ready_o,
  input  work_t     work_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  typedef struct packed {
    logic signed [33:0] c;
    logic signed [34:0] t;
    logic [5:0][31:0]   kk;
    logic [2:0][32:0]   sk;
    logic               zero;
  } prod_t;

  typedef struct packed {
    logic signed [33:0] c;
    logic [5:0][34:0]   tk;
    logic [2:0][32:0]   sk;
    logic               zero;
  } trip_t;

  stage_t            st_q  [NumStages+1];
  stage_t            nxt   [NumStages];
  logic [NumStages:0] sv_q;
  stage_t            init;
  prod_t             p1_d, p1_q;
  trip_t             p2_d, p2_q;
  out_item_t         out_d, out_q;
  logic              p1_v_q, p2_v_q, out_v_q;
  logic              adv;

  // Whole pipeline moves when the output register is free or drained
  assign adv          = !out_v_q || out_ready_i;
  assign work_ready_o = adv;
  assign out_valid_o  = out_v_q;
  assign out_data_o   = out_q;

  // Seed the first slot
  always_comb begin
    init      = '0;
    init.x    = CORDIC_GAIN;
    init.z    = work_data_i.ang;
    init.flip = work_data_i.flip;
    init.zero = work_data_i.zero;
    init.l2   = work_data_i.l2;
    init.mag  = work_data_i.mag;
    init.neg  = work_data_i.neg;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= init;
    end
  end

  // Step stages
  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    always_comb begin
      nxt[g] = stage_step(st_q[g], g, CORDIC_STEPS);
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[g+1] <= nxt[g];
      end
    end
  end

  // Unit vector, cosine and sine, pair products
  always_comb begin
    logic signed [31:0] k [3];
    logic signed [33:0] s;
    logic signed [63:0] pk;
    logic signed [65:0] ps;
    for (int i = 0; i < 3; i++) begin
      k[i] = st_q[NumStages].zero ? 32'sd0 :
             (st_q[NumStages].neg[i] ? -$signed({1'b0, st_q[NumStages].quo[i]})
                                     :  $signed({1'b0, st_q[NumStages].quo[i]}));
    end
    p1_d.c    = st_q[NumStages].flip ? -st_q[NumStages].x : st_q[NumStages].x;
    s         = st_q[NumStages].flip ? -st_q[NumStages].y : st_q[NumStages].y;
    p1_d.t    = 35'(Q30_ONE) - 35'(p1_d.c);
    p1_d.zero = st_q[NumStages].zero;
    pk = k[0] * k[0]; p1_d.kk[0] = 32'(pk >>> 30);
    pk = k[1] * k[1]; p1_d.kk[1] = 32'(pk >>> 30);
    pk = k[2] * k[2]; p1_d.kk[2] = 32'(pk >>> 30);
    pk = k[0] * k[1]; p1_d.kk[3] = 32'(pk >>> 30);
    pk = k[0] * k[2]; p1_d.kk[4] = 32'(pk >>> 30);
    pk = k[1] * k[2]; p1_d.kk[5] = 32'(pk >>> 30);
    for (int i = 0; i < 3; i++) begin
      ps = 66'(k[i]) * 66'(s);
      p1_d.sk[i] = 33'(ps >>> 30);
    end
  end

  // Scale pair products by one minus cosine
  always_comb begin
    logic signed [66:0] pt;
    p2_d.c    = p1_q.c;
    p2_d.sk   = p1_q.sk;
    p2_d.zero = p1_q.zero;
    for (int i = 0; i < 6; i++) begin
      pt = 67'(p1_q.t) * 67'($signed(p1_q.kk[i]));
      p2_d.tk[i] = 35'(pt >>> 30);
    end
  end

  // Sum, round and clamp the nine entries
  always_comb begin
    logic signed [35:0] c, sx, sy, sz, txx, tyy, tzz, txy, txz, tyz;
    c   = 36'(p2_q.c);
    sx  = 36'($signed(p2_q.sk[0]));
    sy  = 36'($signed(p2_q.sk[1]));
    sz  = 36'($signed(p2_q.sk[2]));
    txx = 36'($signed(p2_q.tk[0]));
    tyy = 36'($signed(p2_q.tk[1]));
    tzz = 36'($signed(p2_q.tk[2]));
    txy = 36'($signed(p2_q.tk[3]));
    txz = 36'($signed(p2_q.tk[4]));
    tyz = 36'($signed(p2_q.tk[5]));
    out_d.r00 = to_out(c + txx, ENTRY_FRAC_BITS);
    out_d.r01 = to_out(sz + txy, ENTRY_FRAC_BITS);
    out_d.r02 = to_out(txz - sy, ENTRY_FRAC_BITS);
    out_d.r10 = to_out(txy - sz, ENTRY_FRAC_BITS);
    out_d.r11 = to_out(c + tyy, ENTRY_FRAC_BITS);
    out_d.r12 = to_out(sx + tyz, ENTRY_FRAC_BITS);
    out_d.r20 = to_out(sy + txz, ENTRY_FRAC_BITS);
    out_d.r21 = to_out(tyz - sx, ENTRY_FRAC_BITS);
    out_d.r22 = to_out(c + tzz, ENTRY_FRAC_BITS);
    out_d.axis_was_zero = p2_q.zero;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q  <= p1_d;
      p2_q  <= p2_d;
      out_q <= out_d;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q    <= '0;
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      sv_q    <= {sv_q[NumStages-1:0], work_valid_i};
      p1_v_q  <= sv_q[NumStages];
      p2_v_q  <= p1_v_q;
      out_v_q <= p2_v_q;
    end
  end

endmodule

// ===== rtl/axis_angle_rotation_matrix_unit.sv =====
// Top level of the axis-angle to rotation matrix unit.
//
// Input channel (in_valid_i / in_ready_o / in_data_i): one beat carries an
// axis of any nonzero length and an angle in Q4.12 radians. Output channel
// (out_valid_o / out_ready_i / out_data_o): one beat per input beat, in order,
// holding the nine matrix entries in signed Q(ENTRY_FRAC_BITS) clamped to
// +-1.0, plus a flag set when the axis is all zeros (diagonal = cosine, the
// rest zero).
// Throughput: one beat per cycle while the receiver keeps taking beats. The
// input-to-output path runs through the front register, the two-entry queue,
// the back pipeline of 63 stages (32 square-root digits, then 31 quotient bits
// per axis lane, with the CORDIC steps riding in the first stages) and three
// product/rounding stages.
// Reset clears all valid bits; no output beat is presented until fed.
// When the receiver stalls, the back pipeline freezes as a whole; the queue
// and the front register keep taking beats until they fill, then in_ready_o
// drops.
module axis_angle_rotation_matrix_unit import aarm_pkg::*; #(
  parameter int ENTRY_FRAC_BITS = 14,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic  f_valid, f_ready;
  work_t f_data;
  logic  q_valid, q_ready;
  work_t q_data;

  aarm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .work_valid_o (f_valid),
    .work_ready_i (f_ready),
    .work_data_o  (f_data)
  );

  aarm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_data),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  aarm_back #(
    .ENTRY_FRAC_BITS (ENTRY_FRAC_BITS),
    .CORDIC_STEPS    (CORDIC_STEPS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_valid_i (q_valid),
    .work_ready_o (q_ready),
    .work_data_i  (q_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== rtl/aarm_checker.sv =====
// Port-level checker for the rotation matrix unit, bound to the top level.
module aarm_checker import aarm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled output beat changed");

  // A zero axis gives no off-diagonal terms
  a_zero_offdiag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.axis_was_zero |->
      out_data_i.r01 == '0 && out_data_i.r02 == '0 && out_data_i.r10 == '0 &&
      out_data_i.r12 == '0 && out_data_i.r20 == '0 && out_data_i.r21 == '0)
    else $error("zero axis produced off-diagonal terms");

  // A zero axis gives a scaled identity
  a_zero_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.axis_was_zero |->
      out_data_i.r00 == out_data_i.r11 && out_data_i.r11 == out_data_i.r22)
    else $error("zero axis produced unequal diagonal");

endmodule

bind axis_angle_rotation_matrix_unit aarm_checker u_aarm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
